### rtl/core/assert_macros.svh
// Assertion macros shared by the escape decoder RTL.
// Depends on nothing; clock and reset are taken as clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### rtl/core/esd_pkg.sv
// Package for the escape sequence decoder: widths, codes and result types.
// Depends on nothing.
`timescale 1ns / 1ps

package esd_pkg;

    localparam int CHAR_W  = 16;
    localparam int MODE_W  = 2;
    localparam int COUNT_W = 3;

    // Digit limits of the two numeric escapes.
    localparam int HEX_DIGITS_MAX = 4;
    localparam int OCT_DIGITS_MAX = 6;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // Decoder modes.
    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ESC    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HEX    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OCT    = 2'd3;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_BSLASH = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_LOW_R  = 16'h0072;
    localparam logic [CHAR_W-1:0] CH_LOW_N  = 16'h006E;
    localparam logic [CHAR_W-1:0] CH_LOW_T  = 16'h0074;
    localparam logic [CHAR_W-1:0] CH_LOW_B  = 16'h0062;
    localparam logic [CHAR_W-1:0] CH_LOW_X  = 16'h0078;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 16'h0022;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 16'h0027;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_NINE   = 16'h0039;
    localparam logic [CHAR_W-1:0] CH_SEVEN  = 16'h0037;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 16'h0041;
    localparam logic [CHAR_W-1:0] CH_UP_F   = 16'h0046;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_LOW_F  = 16'h0066;
    localparam logic [CHAR_W-1:0] CODE_CR   = 16'h000D;
    localparam logic [CHAR_W-1:0] CODE_LF   = 16'h000A;
    localparam logic [CHAR_W-1:0] CODE_TAB  = 16'h0009;
    localparam logic [CHAR_W-1:0] CODE_BS   = 16'h0008;

    // One decoded result word.
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              end_marker;
        logic              last_of_run;
    } result_t;

    // Results produced by one input word, in order.
    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

    // Hex digit value with a valid flag in the top bit.
    function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LOW_A && c <= CH_LOW_F))
        begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    // Plain result word with the run flag cleared.
    function automatic result_t make_result(input logic [CHAR_W-1:0] ch, input logic fin);
        result_t r;
        r.out_char    = ch;
        r.end_marker  = fin;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

### rtl/core/esd_if.sv
// Handshake interfaces for the text input and the decoded output channels.
// Depends on esd_pkg.
`timescale 1ns / 1ps

interface esd_in_if;
    import esd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              end_of_text;

    modport source (output valid, output in_char, output end_of_text, input ready);
    modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

interface esd_out_if;
    import esd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              end_marker;
    logic              last_of_run;

    modport source (output valid, output out_char, output end_marker, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_char, input end_marker, input last_of_run,
                    output ready);
endinterface

### rtl/core/escape_sequence_decoder.sv
// Top level of the escape sequence decoder: input word register, decode
// step and result queue. Uses esd_pkg, esd_if, esd_decode, esd_res_fifo.
//
//  Channel   Direction  Payload
//  text      sink       in_char[15:0], end_of_text
//  decoded   source     out_char[15:0], end_marker, last_of_run
//
// A word is registered on acceptance and, once two queue slots are free,
// decoded from that register into the result queue; its results are written
// into the queue registers and are taken from the queue head.
// One word is taken per cycle unless decode waits; two results of a word leave
// singly by the one result port, which sets the rate for runs of such words.
// The decode stage waits while fewer than two of the four queue slots are free.
// Reset is asynchronous, active low, and clears decoder state and the queue.
`timescale 1ns / 1ps

module escape_sequence_decoder (
    input logic           clk,
    input logic           rst_n,
    esd_in_if.sink        text,
    esd_out_if.source     decoded
);
    import esd_pkg::*;

    logic              hold_valid_reg;
    logic [CHAR_W-1:0] hold_char_reg;
    logic              hold_end_reg;
    logic              room_two;
    logic              fire;
    logic              head_valid;
    push_t             push;
    result_t           head;

    assign fire       = hold_valid_reg && room_two;
    assign text.ready = !hold_valid_reg || fire;

    // Input word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            hold_valid_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
        begin
            hold_char_reg <= text.in_char;
            hold_end_reg  <= text.end_of_text;
        end
    end

    // Decode step.
    esd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .in_char     (hold_char_reg),
        .end_of_text (hold_end_reg),
        .push        (push)
    );

    // Result queue.
    esd_res_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room_two   (room_two),
        .head_valid (head_valid),
        .head       (head),
        .pop        (decoded.ready)
    );

    assign decoded.valid       = head_valid;
    assign decoded.out_char    = head.out_char;
    assign decoded.end_marker  = head.end_marker;
    assign decoded.last_of_run = head.last_of_run;

endmodule

### rtl/core/esd_decode.sv
// Escape decoding step: mode, digit count and value registers plus the
// logic that turns one text word into up to two result words. Uses esd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module esd_decode (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  logic [esd_pkg::CHAR_W-1:0] in_char,
    input  logic                      end_of_text,
    output esd_pkg::push_t            push
);
    import esd_pkg::*;

    localparam logic [COUNT_W-1:0] HEX_LIM = COUNT_W'(HEX_DIGITS_MAX);
    localparam logic [COUNT_W-1:0] OCT_LIM = COUNT_W'(OCT_DIGITS_MAX);

    logic [MODE_W-1:0]  mode_reg,  mode_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [CHAR_W-1:0]  value_reg, value_next;

    push_t              res;
    logic [4:0]         hex_d;
    logic               is_oct;
    logic               dig_ok;
    logic [CHAR_W-1:0]  acc;
    logic [COUNT_W-1:0] cnt_inc;
    logic [COUNT_W-1:0] lim;

    // Digit classification and accumulation for the collecting modes.
    always_comb
    begin
        hex_d   = hex_digit(in_char);
        is_oct  = (in_char >= CH_ZERO) && (in_char <= CH_SEVEN);
        cnt_inc = count_reg + COUNT_W'(1);
        if (mode_reg == MODE_HEX)
        begin
            dig_ok = hex_d[4];
            acc    = {value_reg[CHAR_W-5:0], hex_d[3:0]};
            lim    = HEX_LIM;
        end
        else
        begin
            dig_ok = is_oct;
            acc    = {value_reg[CHAR_W-4:0], in_char[2:0]};
            lim    = OCT_LIM;
        end
    end

    // Next state and results of one word.
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        value_next = value_reg;
        res        = '0;

        if (end_of_text)
        begin
            if (mode_reg == MODE_ESC)
            begin
                res.num    = 2'd2;
                res.first  = make_result(CH_BSLASH, 1'b0);
                res.second = make_result('0, 1'b1);
            end
            else if ((mode_reg == MODE_HEX || mode_reg == MODE_OCT) && count_reg != '0)
            begin
                res.num    = 2'd2;
                res.first  = make_result(value_reg, 1'b0);
                res.second = make_result('0, 1'b1);
            end
            else
            begin
                res.num   = 2'd1;
                res.first = make_result('0, 1'b1);
            end
            mode_next  = MODE_NORMAL;
            count_next = '0;
            value_next = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_NORMAL:
                begin
                    if (in_char == CH_BSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        res.num   = 2'd1;
                        res.first = make_result(in_char, 1'b0);
                    end
                end
                MODE_ESC:
                begin
                    mode_next = MODE_NORMAL;
                    res.num   = 2'd1;
                    case (in_char)
                        CH_LOW_R:  res.first = make_result(CODE_CR, 1'b0);
                        CH_LOW_N:  res.first = make_result(CODE_LF, 1'b0);
                        CH_LOW_T:  res.first = make_result(CODE_TAB, 1'b0);
                        CH_LOW_B:  res.first = make_result(CODE_BS, 1'b0);
                        CH_DQUOTE: res.first = make_result(CH_DQUOTE, 1'b0);
                        CH_SQUOTE: res.first = make_result(CH_SQUOTE, 1'b0);
                        CH_BSLASH: res.first = make_result(CH_BSLASH, 1'b0);
                        CH_LOW_X:
                        begin
                            res.num    = 2'd0;
                            mode_next  = MODE_HEX;
                            count_next = '0;
                            value_next = '0;
                        end
                        default:
                        begin
                            if (is_oct)
                            begin
                                // A leading octal digit opens an octal run.
                                if (COUNT_W'(1) >= OCT_LIM)
                                begin
                                    res.first  = make_result({13'd0, in_char[2:0]}, 1'b0);
                                    count_next = '0;
                                    value_next = '0;
                                end
                                else
                                begin
                                    res.num    = 2'd0;
                                    mode_next  = MODE_OCT;
                                    count_next = COUNT_W'(1);
                                    value_next = {13'd0, in_char[2:0]};
                                end
                            end
                            else
                            begin
                                // Unknown escape keeps its backslash.
                                res.num    = 2'd2;
                                res.first  = make_result(CH_BSLASH, 1'b0);
                                res.second = make_result(in_char, 1'b0);
                            end
                        end
                    endcase
                end
                default:
                begin
                    if (dig_ok)
                    begin
                        if (cnt_inc >= lim)
                        begin
                            res.num    = 2'd1;
                            res.first  = make_result(acc, 1'b0);
                            mode_next  = MODE_NORMAL;
                            count_next = '0;
                            value_next = '0;
                        end
                        else
                        begin
                            count_next = cnt_inc;
                            value_next = acc;
                        end
                    end
                    else
                    begin
                        // Non-digit ends the run: value, then the char unless a backslash.
                        res.first  = make_result(value_reg, 1'b0);
                        count_next = '0;
                        value_next = '0;
                        if (in_char == CH_BSLASH)
                        begin
                            res.num   = 2'd1;
                            mode_next = MODE_ESC;
                        end
                        else
                        begin
                            res.num    = 2'd2;
                            res.second = make_result(in_char, 1'b0);
                            mode_next  = MODE_NORMAL;
                        end
                    end
                end
            endcase
        end

        // Flag the final result of this word.
        if (res.num == 2'd1)
        begin
            res.first.last_of_run = 1'b1;
        end
        else if (res.num == 2'd2)
        begin
            res.second.last_of_run = 1'b1;
        end

        if (!fire)
        begin
            res.num = 2'd0;
        end
    end

    assign push = res;

    // Decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            count_reg <= '0;
            value_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            value_reg <= value_next;
        end
    end

    // An end word leaves the decoder in its reset state.
    `ASSERT_CLK(a_end_clears, (fire && end_of_text) |=> (mode_reg == MODE_NORMAL && count_reg == '0 && value_reg == '0), "decoder state not cleared after end word")
    // An end word always produces an end marker as its last result.
    `ASSERT_CLK(a_end_marks, (fire && end_of_text) |-> ((push.num == 2'd1 && push.first.end_marker) || (push.num == 2'd2 && push.second.end_marker)), "end word without end marker")
    // Collecting modes never hold a count at or beyond the limit.
    `ASSERT_NEVER(a_count_limit, (mode_reg == MODE_OCT && count_reg >= OCT_LIM) || (mode_reg == MODE_HEX && count_reg >= HEX_LIM), "digit count beyond limit")

endmodule

### rtl/core/esd_res_fifo.sv
// Four-entry result queue that takes up to two words per cycle and
// hands out one per cycle while it holds a word and pop is high. Uses esd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module esd_res_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  esd_pkg::push_t   push,
    output logic             room_two,
    output logic             head_valid,
    output esd_pkg::result_t head,
    input  logic             pop
);
    import esd_pkg::*;

    result_t            mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg,  count_next;
    logic [FIFO_AW-1:0] wr_ptr_p1;
    logic               do_pop;

    // Pointer and fill arithmetic.
    always_comb
    begin
        do_pop      = pop && head_valid;
        wr_ptr_p1   = wr_ptr_reg + FIFO_AW'(1);
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.num);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(do_pop);
        count_next  = count_reg + FIFO_CW'(push.num) - FIFO_CW'(do_pop);
    end

    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign room_two   = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));

    // Storage writes.
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            mem[wr_ptr_p1] <= push.second;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Words are pushed only when two slots are free.
    `ASSERT_CLK(a_push_room, (push.num != 2'd0) |-> (count_reg <= FIFO_CW'(FIFO_DEPTH - 2)), "push into full result queue")
    // Fill level never exceeds the depth.
    `ASSERT_NEVER(a_fill_bound, count_reg > FIFO_CW'(FIFO_DEPTH), "result queue overflow")
    // Pointers stay consistent with the fill level.
    `ASSERT_CLK(a_ptr_gap, FIFO_AW'(wr_ptr_reg - rd_ptr_reg) == FIFO_AW'(count_reg), "queue pointers disagree with fill")

endmodule
